/* design/dq_pkg.sv */
// Shared types and defaults for the double-ended queue.
`default_nettype none

package dq_pkg;

  localparam int unsigned DepthDefault     = 16;
  localparam int unsigned DataWidthDefault = 32;

  localparam int unsigned FuncW = 3;
  localparam int unsigned ErrW  = 2;

  typedef enum logic [FuncW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

endpackage

`default_nettype wire

/* design/double_ended_queue.sv */
// Top level of the bounded double-ended queue.
//
//  channel  | signals                               | transfer
//  ---------+---------------------------------------+---------------------------
//  command  | start, busy, func_i, value_i          | start high and busy low
//  result   | done_o, front_value_o .. error_o      | done_o high, one cycle
//
// The back end runs one command at a time, in turn through execute and write,
// memory read and result register, and takes no new command until the last
// one is through. A two-entry command queue lets two more commands transfer
// while one runs; busy is high while that queue is full. Reset leaves the queue
// empty. The result strobe cannot be stalled.
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH      = dq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = dq_pkg::DataWidthDefault,
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [dq_pkg::FuncW-1:0]   func_i,
  input  wire logic [DATA_WIDTH-1:0]      value_i,
  output logic                            done_o,
  output logic [DATA_WIDTH-1:0]           front_value_o,
  output logic [DATA_WIDTH-1:0]           back_value_o,
  output logic [CntW-1:0]                 count_o,
  output logic                            is_empty_o,
  output logic                            is_full_o,
  output logic [dq_pkg::ErrW-1:0]         error_o
);

  localparam int unsigned CmdW = $bits(dq_pkg::op_e) + DATA_WIDTH;

  logic            fifo_full, fifo_valid, fifo_push, fifo_pop;
  logic [CmdW-1:0] push_data, cmd_data;

  dq_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .start       (start),
    .func_i      (func_i),
    .value_i     (value_i),
    .fifo_full_i (fifo_full),
    .busy        (busy),
    .push_o      (fifo_push),
    .push_data_o (push_data)
  );

  dq_cmd_fifo #(
    .W(CmdW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (push_data),
    .pop_i       (fifo_pop),
    .full_o      (fifo_full),
    .valid_o     (fifo_valid),
    .data_o      (cmd_data)
  );

  dq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (fifo_valid),
    .cmd_data_i    (cmd_data),
    .cmd_pop_o     (fifo_pop),
    .done_o        (done_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .error_o       (error_o)
  );

endmodule

`default_nettype wire

/* design/dq_front.sv */
// Front end: takes commands and classifies the operation code.
`default_nettype none

module dq_front #(
  parameter int unsigned DATA_WIDTH = dq_pkg::DataWidthDefault
) (
  input  wire logic                                  start,
  input  wire logic [dq_pkg::FuncW-1:0]              func_i,
  input  wire logic [DATA_WIDTH-1:0]                 value_i,
  input  wire logic                                  fifo_full_i,
  output logic                                       busy,
  output logic                                       push_o,
  output logic [$bits(dq_pkg::op_e)+DATA_WIDTH-1:0]  push_data_o
);

  dq_pkg::op_e op;

  always_comb begin
    case (func_i)
      dq_pkg::OP_PUSH_FRONT: op = dq_pkg::OP_PUSH_FRONT;
      dq_pkg::OP_PUSH_BACK:  op = dq_pkg::OP_PUSH_BACK;
      dq_pkg::OP_POP_FRONT:  op = dq_pkg::OP_POP_FRONT;
      dq_pkg::OP_POP_BACK:   op = dq_pkg::OP_POP_BACK;
      default:               op = dq_pkg::OP_QUERY;
    endcase
  end

  assign busy        = fifo_full_i;
  assign push_o      = start && !fifo_full_i;
  assign push_data_o = {op, value_i};

endmodule

`default_nettype wire

/* design/dq_cmd_fifo.sv */
// Two-entry command queue between front end and back end.
`default_nettype none

module dq_cmd_fifo #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] push_data_i,
  input  wire logic         pop_i,
  output logic              full_o,
  output logic              valid_o,
  output logic [W-1:0]      data_o
);

  logic [W-1:0] entry_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* design/dq_back.sv */
// Back end: ring buffer, pointer update and result generation.
`default_nettype none

module dq_back #(
  parameter int unsigned DEPTH      = dq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = dq_pkg::DataWidthDefault,
  localparam int unsigned IdxW      = $clog2(DEPTH),
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cmd_valid_i,
  input  wire logic [$bits(dq_pkg::op_e)+DATA_WIDTH-1:0] cmd_data_i,
  output logic                                       cmd_pop_o,
  output logic                                       done_o,
  output logic [DATA_WIDTH-1:0]                      front_value_o,
  output logic [DATA_WIDTH-1:0]                      back_value_o,
  output logic [CntW-1:0]                            count_o,
  output logic                                       is_empty_o,
  output logic                                       is_full_o,
  output logic [dq_pkg::ErrW-1:0]                    error_o
);

  typedef enum logic [1:0] {
    S_EXEC,
    S_READ,
    S_RESP
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  state_e             state_q, state_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic [IdxW-1:0]    tail_q, tail_d;
  logic [CntW-1:0]    count_q, count_d;
  dq_pkg::err_e       err_q, err_d;
  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  logic [IdxW-1:0]    head_inc, head_dec, tail_inc, tail_dec;
  logic [DATA_WIDTH-1:0] rd_front_q, rd_back_q;
  dq_pkg::op_e        cmd_op;
  logic [DATA_WIDTH-1:0] cmd_value;
  logic               q_empty, q_full;

  assign cmd_op    = dq_pkg::op_e'(cmd_data_i[$bits(dq_pkg::op_e)+DATA_WIDTH-1:DATA_WIDTH]);
  assign cmd_value = cmd_data_i[DATA_WIDTH-1:0];

  assign head_inc = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign tail_inc = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? LastIdx : tail_q - 1'b1;

  assign q_empty = (count_q == '0);
  assign q_full  = (count_q == FullCnt);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    err_d     = err_q;
    mem_we    = 1'b0;
    mem_waddr = tail_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      S_EXEC: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          err_d     = dq_pkg::ERR_OK;
          state_d   = S_READ;
          case (cmd_op)
            dq_pkg::OP_PUSH_FRONT: begin
              if (q_full) begin
                err_d = dq_pkg::ERR_FULL;
              end else begin
                head_d    = head_dec;
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                count_d   = count_q + 1'b1;
              end
            end
            dq_pkg::OP_PUSH_BACK: begin
              if (q_full) begin
                err_d = dq_pkg::ERR_FULL;
              end else begin
                tail_d    = tail_inc;
                mem_we    = 1'b1;
                mem_waddr = tail_q;
                count_d   = count_q + 1'b1;
              end
            end
            dq_pkg::OP_POP_FRONT: begin
              if (q_empty) begin
                err_d = dq_pkg::ERR_EMPTY;
              end else begin
                head_d  = head_inc;
                count_d = count_q - 1'b1;
              end
            end
            dq_pkg::OP_POP_BACK: begin
              if (q_empty) begin
                err_d = dq_pkg::ERR_EMPTY;
              end else begin
                tail_d  = tail_dec;
                count_d = count_q - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ:  state_d = S_RESP;
      S_RESP:  state_d = S_EXEC;
      default: state_d = S_EXEC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_EXEC;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      err_q         <= dq_pkg::ERR_OK;
      done_o        <= 1'b0;
      front_value_o <= '0;
      back_value_o  <= '0;
      count_o       <= '0;
      is_empty_o    <= 1'b1;
      is_full_o     <= 1'b0;
      error_o       <= dq_pkg::ERR_OK;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      err_q   <= err_d;
      done_o  <= (state_q == S_RESP);
      if (state_q == S_RESP) begin
        front_value_o <= q_empty ? '0 : rd_front_q;
        back_value_o  <= q_empty ? '0 : rd_back_q;
        count_o       <= count_q;
        is_empty_o    <= q_empty;
        is_full_o     <= q_full;
        error_o       <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd_value;
    end
    rd_front_q <= mem[head_q];
    rd_back_q  <= mem[tail_dec];
  end

endmodule

`default_nettype wire

/* design/dq_checker.sv */
// Port-level checks for the double-ended queue, bound to the top level.
`default_nettype none

module dq_checker #(
  parameter int unsigned DEPTH      = dq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = dq_pkg::DataWidthDefault,
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     done_o,
  input wire logic [DATA_WIDTH-1:0]    front_value_o,
  input wire logic [DATA_WIDTH-1:0]    back_value_o,
  input wire logic [CntW-1:0]          count_o,
  input wire logic                     is_empty_o,
  input wire logic                     is_full_o,
  input wire logic [dq_pkg::ErrW-1:0]  error_o
);

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == (count_o == '0)))
    else $error("empty flag disagrees with count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_full_o == (count_o == CntW'(DEPTH))))
    else $error("full flag disagrees with count");

  a_empty_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (front_value_o == '0 && back_value_o == '0))
    else $error("empty queue shows nonzero values");

  a_err_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_o == dq_pkg::ERR_FULL) |-> is_full_o)
    else $error("full error on a queue that is not full");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held two cycles");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_dq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .done_o        (done_o),
  .front_value_o (front_value_o),
  .back_value_o  (back_value_o),
  .count_o       (count_o),
  .is_empty_o    (is_empty_o),
  .is_full_o     (is_full_o),
  .error_o       (error_o)
);

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for double_ended_queue: random and directed commands.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DW     = 32;
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned FuncW  = dq_pkg::FuncW;
  localparam int unsigned N_RAND = 1000;

  localparam logic [FuncW-1:0] FuncSpareLo  = 3'd5;
  localparam logic [FuncW-1:0] FuncSpareMid = 3'd6;
  localparam logic [FuncW-1:0] FuncSpareHi  = 3'd7;

  typedef struct packed {
    logic [DW-1:0]   front;
    logic [DW-1:0]   back;
    logic [CntW-1:0] count;
    logic            empty;
    logic            full;
    dq_pkg::err_e    err;
  } status_t;

  typedef struct {
    logic [FuncW-1:0] func;
    logic [DW-1:0]    value;
    int unsigned      gap;
    bit               drain;
  } cmd_t;

  logic                    clk_i   = 1'b0;
  logic                    rst_ni  = 1'b0;
  logic                    start   = 1'b0;
  logic [FuncW-1:0]        func_i  = '0;
  logic [DW-1:0]           value_i = '0;
  logic                    busy;
  logic                    done_o;
  logic [DW-1:0]           front_value_o;
  logic [DW-1:0]           back_value_o;
  logic [CntW-1:0]         count_o;
  logic                    is_empty_o;
  logic                    is_full_o;
  logic [dq_pkg::ErrW-1:0] error_o;

  cmd_t    cmd_q[$];
  status_t status_due_q[$];

  logic [DW-1:0] dq_store[DEPTH];
  int unsigned   dq_head  = 0;
  int unsigned   dq_count = 0;

  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_full_err  = 0;
  int unsigned n_empty_err = 0;
  int unsigned n_fail      = 0;

  double_ended_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .error_o       (error_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic status_t deque_apply(logic [FuncW-1:0] fn,
                                          logic [DW-1:0] val);
    status_t s;
    s.err = dq_pkg::ERR_OK;
    case (fn)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        if (dq_count >= DEPTH) begin
          s.err = dq_pkg::ERR_FULL;
        end else if (fn == dq_pkg::OP_PUSH_FRONT) begin
          dq_head = (dq_head + DEPTH - 1) % DEPTH;
          dq_store[dq_head] = val;
          dq_count++;
        end else begin
          dq_count++;
          dq_store[(dq_head + dq_count - 1) % DEPTH] = val;
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
        if (dq_count == 0) begin
          s.err = dq_pkg::ERR_EMPTY;
        end else begin
          if (fn == dq_pkg::OP_POP_FRONT) dq_head = (dq_head + 1) % DEPTH;
          dq_count--;
        end
      end
      default: ;
    endcase
    s.front = (dq_count != 0) ? dq_store[dq_head] : '0;
    s.back  = (dq_count != 0) ? dq_store[(dq_head + dq_count - 1) % DEPTH] : '0;
    s.count = CntW'(dq_count);
    s.empty = (dq_count == 0);
    s.full  = (dq_count == DEPTH);
    return s;
  endfunction

  function automatic void add_cmd(logic [FuncW-1:0] fn, logic [DW-1:0] val,
                                  int unsigned gap);
    cmd_t c;
    c.func  = fn;
    c.value = val;
    c.gap   = gap;
    c.drain = 1'b0;
    cmd_q.push_back(c);
  endfunction

  function automatic void add_drain();
    cmd_t c;
    c.func  = dq_pkg::OP_QUERY;
    c.value = '0;
    c.gap   = 0;
    c.drain = 1'b1;
    cmd_q.push_back(c);
  endfunction

  task automatic report_fail(string what, status_t exp, status_t got);
    n_fail++;
    if (n_fail <= 10) begin
      $display("%0t %s: exp f=%h b=%h n=%0d e=%b F=%b err=%0d",
               $time, what, exp.front, exp.back, exp.count, exp.empty, exp.full, exp.err);
      $display("    got f=%h b=%h n=%0d e=%b F=%b err=%0d",
               got.front, got.back, got.count, got.empty, got.full, got.err);
    end
  endtask

  // stimulus
  initial begin
    int unsigned made;
    int unsigned phase_len;
    int unsigned bias;
    int unsigned idle_mode;
    int unsigned r;
    int unsigned push_pct;
    int unsigned gap;
    logic [FuncW-1:0] fn;
    logic [DW-1:0]    val;

    add_cmd(FuncSpareHi, $urandom, 0);
    add_cmd(dq_pkg::OP_POP_FRONT, $urandom, 0);
    add_cmd(dq_pkg::OP_POP_BACK, $urandom, 1);
    add_cmd(dq_pkg::OP_PUSH_FRONT, '1, 0);
    add_cmd(dq_pkg::OP_PUSH_BACK, '0, 0);
    add_cmd(dq_pkg::OP_POP_FRONT, $urandom, 2);
    add_cmd(dq_pkg::OP_POP_BACK, $urandom, 0);
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0:       val = 32'h8000_0000;
        1:       val = 32'h0000_0001;
        2:       val = '1;
        default: val = $urandom;
      endcase
      add_cmd((i % 2) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT, val, 0);
    end
    add_cmd(dq_pkg::OP_PUSH_FRONT, $urandom, 0);
    add_cmd(dq_pkg::OP_PUSH_BACK, $urandom, 0);
    add_cmd(FuncSpareLo, $urandom, 0);
    add_cmd(FuncSpareMid, $urandom, 0);

    made = 0;
    while (made < N_RAND) begin
      phase_len = $urandom_range(8, 40);
      bias      = $urandom_range(0, 2);
      idle_mode = $urandom_range(0, 3);
      push_pct  = (bias == 0) ? 80 : (bias == 1) ? 20 : 45;
      for (int i = 0; i < phase_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          fn = FuncW'($urandom_range(dq_pkg::OP_QUERY, FuncSpareHi));
        end else if ($urandom_range(0, 99) < push_pct) begin
          fn = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
        end else begin
          fn = $urandom_range(0, 1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
        end
        r = $urandom_range(0, 99);
        val = (r < 5) ? '0 : (r < 10) ? '1 : DW'($urandom);
        if (idle_mode == 0) begin
          gap = 0;
        end else begin
          r = $urandom_range(0, 99);
          gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
        add_cmd(fn, val, gap);
        made++;
        if (made == N_RAND / 2 || $urandom_range(0, 99) == 0) add_drain();
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    int unsigned gap_left;
    int unsigned cur_gap;
    logic        nxt_start;
    cmd_t        c;
    if (!rst_ni) begin
      start    <= 1'b0;
      func_i   <= '0;
      value_i  <= '0;
      gap_left = 0;
      cur_gap  = 0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        status_due_q.push_back(deque_apply(func_i, value_i));
        n_sent++;
        nxt_start = 1'b0;
        gap_left  = cur_gap;
      end
      if (!nxt_start) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (cmd_q.size() != 0) begin
          if (cmd_q[0].drain) begin
            if (status_due_q.size() == 0) void'(cmd_q.pop_front());
          end else begin
            c = cmd_q.pop_front();
            func_i    <= c.func;
            value_i   <= c.value;
            cur_gap   = c.gap;
            nxt_start = 1'b1;
          end
        end
      end
      start <= nxt_start;
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    status_t got;
    status_t exp;
    if (rst_ni && done_o) begin
      got.front = front_value_o;
      got.back  = back_value_o;
      got.count = count_o;
      got.empty = is_empty_o;
      got.full  = is_full_o;
      got.err   = dq_pkg::err_e'(error_o);
      if (status_due_q.size() == 0) begin
        exp = '0;
        report_fail("unexpected result", exp, got);
      end else begin
        exp = status_due_q.pop_front();
        n_checked++;
        if (exp.err == dq_pkg::ERR_FULL)  n_full_err++;
        if (exp.err == dq_pkg::ERR_EMPTY) n_empty_err++;
        if (got !== exp) report_fail("mismatch", exp, got);
      end
    end
  end

  initial begin
    status_t none;
    none = '0;
    wait (rst_ni);
    do @(posedge clk_i);
    while (cmd_q.size() != 0 || start || status_due_q.size() != 0);
    repeat (12) @(posedge clk_i);
    while (status_due_q.size() != 0) begin
      report_fail("missing result", status_due_q.pop_front(), none);
    end
    $display("transferred %0d commands, checked %0d results", n_sent, n_checked);
    $display("push-on-full %0d, pop-on-empty %0d, failures %0d",
             n_full_err, n_empty_err, n_fail);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* filelist.f */
design/dq_pkg.sv
design/dq_front.sv
design/dq_cmd_fifo.sv
design/dq_back.sv
design/double_ended_queue.sv
design/dq_checker.sv
dv/tb_top.sv
